### rtl/ssg_pkg.sv
package ssg_pkg;

  // Width of the grid extent registers.
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_ADDR_BITS = 1;

  // Configuration register indexes.
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_WIDTH  = 1'b0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_GRID_HEIGHT = 1'b1;

  // Request commands.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_NEXT  = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_COORD     = 2'd0;
  localparam logic [1:0] ST_FOUND     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       start;      // latch the center and check it against the grid
    logic       init;       // set up ring bounds for a new spiral
    logic       clear_run;  // stop the running spiral
    logic       step;       // advance along the active side
    logic       ring;       // open the next ring or detect the end
    logic       set_side;   // set up the next side of the ring
    logic       load_out;   // load the result register
    logic [1:0] out_status; // status to load with the result
  } ssg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic running;
    logic bad;
    logic need_side;
    logic side_zero;
    logic side_last;
    logic exhausted;
    logic skip;
  } ssg_sts_t;

endpackage

### rtl/ssg_if.sv
// Request channel: one command with its center and hit flag.
interface ssg_req_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [COORD_BITS-1:0] center_x;
  logic [COORD_BITS-1:0] center_y;
  logic                  hit;

  modport source (output valid, command, center_x, center_y, hit, input ready);
  modport sink (input valid, command, center_x, center_y, hit, output ready);
endinterface

// Result channel: one coordinate or a status per request.
interface ssg_rsp_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] coord_x;
  logic [COORD_BITS-1:0] coord_y;
  logic [1:0]            status;

  modport source (output valid, coord_x, coord_y, status, input ready);
  modport sink (input valid, coord_x, coord_y, status, output ready);
endinterface

// Configuration write channel.
interface ssg_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [ssg_pkg::CFG_ADDR_BITS-1:0]  addr;
  logic [ssg_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### rtl/ssg_ctrl.sv
module ssg_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_command_i,
  input  logic              in_hit_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output ssg_pkg::ssg_cmd_t cmd_o,
  input  ssg_pkg::ssg_sts_t sts_i
);
  import ssg_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INIT = 3'd1;
  localparam logic [2:0] S_RING = 3'd2;
  localparam logic [2:0] S_SET  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] st_q, st_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Sequencing of one request.
  always_comb begin
    state_d = state_q;
    st_d    = st_q;
    cmd_o   = '0;
    cmd_o.out_status = st_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_command_i == CMD_START) begin
            cmd_o.start = 1'b1;
            state_d     = S_INIT;
          end else if (!sts_i.running) begin
            st_d    = ST_BAD;
            state_d = S_EMIT;
          end else if (in_hit_i) begin
            cmd_o.clear_run = 1'b1;
            st_d            = ST_FOUND;
            state_d         = S_EMIT;
          end else if (!sts_i.need_side) begin
            cmd_o.step = 1'b1;
            st_d       = ST_COORD;
            state_d    = S_EMIT;
          end else begin
            state_d = sts_i.side_zero ? S_RING : S_SET;
          end
        end
      end
      S_INIT: begin
        if (sts_i.bad) begin
          st_d = ST_BAD;
        end else begin
          cmd_o.init = 1'b1;
          st_d       = ST_COORD;
        end
        state_d = S_EMIT;
      end
      S_RING: begin
        cmd_o.ring = 1'b1;
        if (sts_i.exhausted) begin
          st_d    = ST_EXHAUSTED;
          state_d = S_EMIT;
        end else begin
          state_d = S_SET;
        end
      end
      S_SET: begin
        cmd_o.set_side = 1'b1;
        if (sts_i.skip) begin
          state_d = sts_i.side_last ? S_RING : S_SET;
        end else begin
          st_d    = ST_COORD;
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // The result register is full from a load until the receiver takes it.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.load_out) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= ST_COORD;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

### rtl/ssg_datapath.sv
module ssg_datapath #(
  parameter int COORD_BITS = 12
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  ssg_pkg::ssg_cmd_t                  cmd_i,
  output ssg_pkg::ssg_sts_t                  sts_o,
  input  logic [COORD_BITS-1:0]              center_x_i,
  input  logic [COORD_BITS-1:0]              center_y_i,
  input  logic [ssg_pkg::CFG_DATA_BITS-1:0]  grid_width_i,
  input  logic [ssg_pkg::CFG_DATA_BITS-1:0]  grid_height_i,
  output logic [COORD_BITS-1:0]              coord_x_o,
  output logic [COORD_BITS-1:0]              coord_y_o,
  output logic [1:0]                         status_o
);
  import ssg_pkg::*;

  localparam int EXT_BITS  = COORD_BITS + 1;
  localparam int STEP_BITS = COORD_BITS + 2;
  localparam int SW        = COORD_BITS + 3;
  localparam int CMP_BITS  = (EXT_BITS > CFG_DATA_BITS) ? EXT_BITS : CFG_DATA_BITS;
  localparam logic [CMP_BITS-1:0] EXT_CAP = {{(CMP_BITS-1){1'b0}}, 1'b1} << COORD_BITS;

  // Clamp a position on a side to the grid.
  function automatic logic signed [SW-1:0] clamp_axis(input logic signed [SW-1:0] v,
                                                       input logic signed [SW-1:0] hi);
    logic signed [SW-1:0] r;
    r = v;
    if (v[SW-1]) r = '0;
    else if (v > hi) r = hi;
    return r;
  endfunction

  logic [CMP_BITS-1:0] gw_wide, gh_wide;
  logic [EXT_BITS-1:0] ext_w, ext_h, cx_e, cy_e;
  logic signed [SW-1:0] wm1, hm1;

  logic                  running_q;
  logic                  bad_q;
  logic [EXT_BITS-1:0]   dist_q [4];
  logic signed [SW-1:0]  corner_x_q, corner_y_q;
  logic [STEP_BITS-1:0]  ring_steps_q, inner_q, outer_q;
  logic [1:0]            side_q;
  logic signed [SW-1:0]  scan_cur_q, scan_end_q, fixed_q;

  // Grid extents, capped at the coordinate range.
  assign gw_wide = CMP_BITS'(grid_width_i);
  assign gh_wide = CMP_BITS'(grid_height_i);
  assign ext_w   = (gw_wide > EXT_CAP) ? EXT_CAP[EXT_BITS-1:0] : gw_wide[EXT_BITS-1:0];
  assign ext_h   = (gh_wide > EXT_CAP) ? EXT_CAP[EXT_BITS-1:0] : gh_wide[EXT_BITS-1:0];
  assign wm1     = $signed({2'b00, ext_w}) - SW'(1);
  assign hm1     = $signed({2'b00, ext_h}) - SW'(1);
  assign cx_e    = EXT_BITS'(center_x_i);
  assign cy_e    = EXT_BITS'(center_y_i);

  // Minimum and maximum distance from the center to the grid edges.
  logic [EXT_BITS-1:0] mn01, mn23, mx01, mx23, dmin, dmax;
  always_comb begin
    mn01 = (dist_q[0] < dist_q[1]) ? dist_q[0] : dist_q[1];
    mn23 = (dist_q[2] < dist_q[3]) ? dist_q[2] : dist_q[3];
    mx01 = (dist_q[0] > dist_q[1]) ? dist_q[0] : dist_q[1];
    mx23 = (dist_q[2] > dist_q[3]) ? dist_q[2] : dist_q[3];
    dmin = (mn01 < mn23) ? mn01 : mn23;
    dmax = (mx01 > mx23) ? mx01 : mx23;
  end

  // Set-up of the next side: sides run +y, +x, -y, -x.
  logic                 side_y, side_fwd, outer_ring, skip;
  logic signed [SW-1:0] p_pos, other, steps_s, it_pos, dest_pos;
  logic signed [SW-1:0] lim_other, lim_axis;
  always_comb begin
    side_y     = ~side_q[0];
    side_fwd   = ~side_q[1];
    p_pos      = side_y ? corner_y_q : corner_x_q;
    other      = side_y ? corner_x_q : corner_y_q;
    steps_s    = $signed({1'b0, ring_steps_q});
    it_pos     = side_fwd ? p_pos + SW'(1) : p_pos - SW'(1);
    dest_pos   = side_fwd ? p_pos + steps_s : p_pos - steps_s;
    outer_ring = ring_steps_q > inner_q;
    lim_other  = side_y ? wm1 : hm1;
    lim_axis   = side_y ? hm1 : wm1;
    skip       = outer_ring && (other[SW-1] || (other > lim_other));
  end

  // The side being walked is the one before side_q.
  logic [1:0]           cur_side;
  logic signed [SW-1:0] emit_x, emit_y;
  always_comb begin
    cur_side = side_q - 2'd1;
    if (ring_steps_q == '0) begin
      emit_x = corner_x_q;
      emit_y = corner_y_q;
    end else if (!cur_side[0]) begin
      emit_x = fixed_q;
      emit_y = scan_cur_q;
    end else begin
      emit_x = scan_cur_q;
      emit_y = fixed_q;
    end
  end

  assign sts_o.running   = running_q;
  assign sts_o.bad       = bad_q;
  assign sts_o.need_side = (ring_steps_q == '0) || (scan_cur_q == scan_end_q);
  assign sts_o.side_zero = (side_q == 2'd0);
  assign sts_o.side_last = (side_q == 2'd3);
  assign sts_o.exhausted = (ring_steps_q >= outer_q);
  assign sts_o.skip      = skip;

  // Spiral state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= 1'b0;
      bad_q        <= 1'b0;
      dist_q       <= '{default: '0};
      corner_x_q   <= '0;
      corner_y_q   <= '0;
      ring_steps_q <= '0;
      inner_q      <= '0;
      outer_q      <= '0;
      side_q       <= '0;
      scan_cur_q   <= '0;
      scan_end_q   <= '0;
      fixed_q      <= '0;
    end else begin
      if (cmd_i.start) begin
        running_q <= 1'b0;
        bad_q     <= (ext_w == '0) || (ext_h == '0) || (cx_e >= ext_w) || (cy_e >= ext_h);
        dist_q[0] <= cx_e;
        dist_q[1] <= ext_w - cx_e - EXT_BITS'(1);
        dist_q[2] <= cy_e;
        dist_q[3] <= ext_h - cy_e - EXT_BITS'(1);
      end
      if (cmd_i.init) begin
        inner_q      <= {dmin, 1'b0};
        outer_q      <= {dmax, 1'b0};
        corner_x_q   <= $signed({2'b00, dist_q[0]});
        corner_y_q   <= $signed({2'b00, dist_q[2]});
        ring_steps_q <= '0;
        side_q       <= '0;
        scan_cur_q   <= '0;
        scan_end_q   <= '0;
        fixed_q      <= '0;
        running_q    <= 1'b1;
      end
      if (cmd_i.clear_run) begin
        running_q <= 1'b0;
      end
      if (cmd_i.step) begin
        scan_cur_q <= cur_side[1] ? scan_cur_q - SW'(1) : scan_cur_q + SW'(1);
      end
      if (cmd_i.ring) begin
        if (ring_steps_q >= outer_q) begin
          running_q <= 1'b0;
        end else begin
          ring_steps_q <= ring_steps_q + STEP_BITS'(2);
          corner_x_q   <= corner_x_q - SW'(1);
          corner_y_q   <= corner_y_q - SW'(1);
        end
      end
      if (cmd_i.set_side) begin
        side_q <= side_q + 2'd1;
        if (side_y) corner_y_q <= dest_pos;
        else corner_x_q <= dest_pos;
        if (!skip) begin
          scan_cur_q <= outer_ring ? clamp_axis(it_pos, lim_axis) : it_pos;
          scan_end_q <= outer_ring ? clamp_axis(dest_pos, lim_axis) : dest_pos;
          fixed_q    <= other;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_o <= ST_COORD;
    end else if (cmd_i.load_out) begin
      status_o <= cmd_i.out_status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      coord_x_o <= (cmd_i.out_status == ST_COORD) ? emit_x[COORD_BITS-1:0] : '0;
      coord_y_o <= (cmd_i.out_status == ST_COORD) ? emit_y[COORD_BITS-1:0] : '0;
    end
  end

endmodule

### rtl/square_spiral_scan_generator_top.sv
// Square-spiral scan generator.
// Requests arrive on in_i: a start command carries a center and is answered
// with the center coordinate; a next command carries the hit flag for the
// last coordinate and is answered with the next coordinate, found (on a hit)
// or exhausted (after the circumscribed ring). Bad requests get status 3.
// Every request gets exactly one result on out_o, in order.
// Grid extents are written on cfg_i (index 0 width, index 1 height); the
// channel is always ready.
// A start passes through an init state and a next that stays on its side goes
// straight to the emit state; otherwise each ring opened and each side set up
// (also a skipped off-grid side) adds a state visit before emit, since the side
// sequencer handles one side per cycle. A new request is taken once the previous
// one has been loaded into the result register.
// While the receiver stalls, the result register holds its item and the
// block can take one more request, which then waits for the register.
// Reset clears the spiral (next answers bad request) and sets both extents to 1.
module square_spiral_scan_generator_top #(
  parameter int COORD_BITS = 12
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssg_req_if.sink   in_i,
  ssg_rsp_if.source out_o,
  ssg_cfg_if.sink   cfg_i
);
  import ssg_pkg::*;

  logic [CFG_DATA_BITS-1:0] grid_width_q, grid_height_q;
  ssg_cmd_t cmd;
  ssg_sts_t sts;

  // Configuration registers.
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= CFG_DATA_BITS'(1);
      grid_height_q <= CFG_DATA_BITS'(1);
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        REG_GRID_WIDTH:  grid_width_q  <= cfg_i.data;
        REG_GRID_HEIGHT: grid_height_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  ssg_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_command_i (in_i.command),
    .in_hit_i     (in_i.hit),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  ssg_datapath #(.COORD_BITS(COORD_BITS)) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .center_x_i    (in_i.center_x),
    .center_y_i    (in_i.center_y),
    .grid_width_i  (grid_width_q),
    .grid_height_i (grid_height_q),
    .coord_x_o     (out_o.coord_x),
    .coord_y_o     (out_o.coord_y),
    .status_o      (out_o.status)
  );

  // A result that is not a coordinate carries zero coordinates.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_COORD)) |->
      ((out_o.coord_x == '0) && (out_o.coord_y == '0)))
    else $error("non-coordinate result with nonzero coordinates");

  // Only one request is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("request taken while another is in work");

  // Found, exhausted and bad request all leave the spiral stopped.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out && (cmd.out_status != ST_COORD)) |=> !sts.running)
    else $error("spiral still running after a terminal result");

  // A loaded result is offered on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_out |=> out_o.valid)
    else $error("loaded result not offered");

endmodule
